>>> sv/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  // Header byte fields
  localparam logic [7:0] LEN_MASK = 8'h7F;
  localparam logic [7:0] RUN_FLAG = 8'h80;

  // Configuration register indexes
  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [1:0] CFG_PIXEL_COUNT     = 2'd1;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OVERRUN = 2'd1;
  localparam logic [1:0] STATUS_EARLY   = 2'd2;

  // Command queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef enum logic [1:0] {
    CMD_PIXEL,
    CMD_PIXEL_EARLY,
    CMD_OVERRUN,
    CMD_EARLY
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] pixel;
    logic [7:0]  rep;
    logic        done;
  } cmd_t;

endpackage

>>> sv/tga_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// TGA run-length pixel decoder, one compressed byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle, sustained, as long as the
// four-entry command queue between the parser and the result stage has room;
// a stalled result side backs up into that queue before in_ready drops. A
// result passes through the command queue and then the output register
// before it appears on the output. Run packets give one result carrying the
// repeat count; raw packets give one result per pixel. Configuration writes
// take effect at once and are accepted every cycle; write them only while
// the decoder is idle. No clearing pass follows reset.
module tga_rle_pixel_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tga_rle_pkg::in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tga_rle_pkg::out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tga_rle_pkg::*;

  logic [2:0]  bpp_r;
  logic [31:0] pixel_count_r;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_not_empty;
  cmd_t        push_cmd;
  cmd_t        head_cmd;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r         <= 3'd1;
      pixel_count_r <= 32'd1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BYTES_PER_PIXEL) begin
        bpp_r <= cfg_data[2:0];
      end else if (cfg_index == CFG_PIXEL_COUNT) begin
        pixel_count_r <= cfg_data;
      end
    end
  end

  tga_rle_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .bytes_per_pixel (bpp_r),
    .pixel_count     (pixel_count_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  tga_rle_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  tga_rle_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> sv/tga_rle_front.sv
// ----------------------------------------------------------------------------
// tga_rle_front
// Byte parser: decodes packet headers, gathers pixel bytes, keeps the image
// pixel count and issues one command per result into the queue.
// ----------------------------------------------------------------------------
module tga_rle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tga_rle_pkg::in_t    in_data,
  input  logic [2:0]          bytes_per_pixel,
  input  logic [31:0]         pixel_count,
  input  logic                q_full,
  output logic                q_push,
  output tga_rle_pkg::cmd_t   q_cmd
);
  import tga_rle_pkg::*;

  logic        in_packet_r, in_packet_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [31:0] done_r, done_nxt;

  logic        take;
  logic [1:0]  pos_last;
  logic [7:0]  len;
  logic [32:0] need;
  logic [31:0] gathered;
  logic [7:0]  rep;
  logic [7:0]  left_after;
  logic [31:0] done_sum;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Map pixel size to index of its final byte; out-of-range sizes clamp
  always_comb begin
    unique case (bytes_per_pixel)
      3'd0, 3'd1: pos_last = 2'd0;
      3'd2:       pos_last = 2'd1;
      3'd3:       pos_last = 2'd2;
      default:    pos_last = 2'd3;
    endcase
  end

  // Header length and overrun sum, pixel gather, completion counts
  assign len      = (in_data.data_byte & LEN_MASK) + 8'd1;
  assign need     = {1'b0, done_r} + {25'd0, len};
  assign gathered = (pos_r == 2'd0) ? {24'd0, in_data.data_byte}
                                    : gather_r | ({24'd0, in_data.data_byte} << {pos_r, 3'b000});
  assign rep        = run_r ? left_r : 8'd1;
  assign left_after = run_r ? 8'd0 : left_r - 8'd1;
  assign done_sum   = done_r + {24'd0, rep};

  // Advance parser state for an accepted byte
  always_comb begin
    in_packet_nxt = in_packet_r;
    run_nxt       = run_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    gather_nxt    = gather_r;
    done_nxt      = done_r;
    q_push        = 1'b0;
    q_cmd.kind    = CMD_PIXEL;
    q_cmd.pixel   = gathered;
    q_cmd.rep     = rep;
    q_cmd.done    = 1'b0;

    if (take) begin
      if (!in_packet_r) begin
        if (need > {1'b0, pixel_count}) begin
          q_push     = 1'b1;
          q_cmd.kind = CMD_OVERRUN;
        end else if (in_data.last_byte) begin
          q_push     = 1'b1;
          q_cmd.kind = CMD_EARLY;
        end
        if (q_push) begin
          in_packet_nxt = 1'b0;
          run_nxt       = 1'b0;
          left_nxt      = 8'd0;
          done_nxt      = 32'd0;
        end else begin
          in_packet_nxt = 1'b1;
          run_nxt       = (in_data.data_byte & RUN_FLAG) != 8'd0;
          left_nxt      = len;
        end
        pos_nxt    = 2'd0;
        gather_nxt = 32'd0;
      end else if (pos_r < pos_last) begin
        if (in_data.last_byte) begin
          q_push        = 1'b1;
          q_cmd.kind    = CMD_EARLY;
          in_packet_nxt = 1'b0;
          run_nxt       = 1'b0;
          left_nxt      = 8'd0;
          pos_nxt       = 2'd0;
          gather_nxt    = 32'd0;
          done_nxt      = 32'd0;
        end else begin
          pos_nxt    = pos_r + 2'd1;
          gather_nxt = gathered;
        end
      end else begin
        // Pixel complete
        q_push     = 1'b1;
        pos_nxt    = 2'd0;
        gather_nxt = 32'd0;
        priority if (done_sum >= pixel_count) begin
          q_cmd.done = 1'b1;
        end else if (in_data.last_byte) begin
          q_cmd.kind = CMD_PIXEL_EARLY;
        end else begin
          q_cmd.kind = CMD_PIXEL;
        end
        if (q_cmd.done || in_data.last_byte) begin
          in_packet_nxt = 1'b0;
          run_nxt       = 1'b0;
          left_nxt      = 8'd0;
          done_nxt      = 32'd0;
        end else begin
          left_nxt      = left_after;
          in_packet_nxt = left_after != 8'd0;
          done_nxt      = done_sum;
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      run_r       <= 1'b0;
      left_r      <= 8'd0;
      pos_r       <= 2'd0;
      gather_r    <= 32'd0;
      done_r      <= 32'd0;
    end else begin
      in_packet_r <= in_packet_nxt;
      run_r       <= run_nxt;
      left_r      <= left_nxt;
      pos_r       <= pos_nxt;
      gather_r    <= gather_nxt;
      done_r      <= done_nxt;
    end
  end

  a_open_packet_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    in_packet_r |-> left_r != 8'd0)
    else $error("open packet with no pixels left");

  a_header_at_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !in_packet_r |-> (pos_r == 2'd0 && gather_r == 32'd0))
    else $error("byte gather not cleared outside a packet");

endmodule

>>> sv/tga_rle_fifo.sv
// ----------------------------------------------------------------------------
// tga_rle_fifo
// Short command queue that decouples the parser from the result stage.
// ----------------------------------------------------------------------------
module tga_rle_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tga_rle_pkg::cmd_t  push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output tga_rle_pkg::cmd_t  head_cmd
);
  import tga_rle_pkg::*;

  cmd_t                 mem [FifoDepth];
  logic [FifoAw-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [FifoAw-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [FifoAw:0]      count_r, count_nxt;

  assign full      = count_r == (FifoAw+1)'(FifoDepth);
  assign not_empty = count_r != '0;
  assign head_cmd  = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FifoAw'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + FifoAw'(1) : rd_ptr_r;
    count_nxt  = count_r + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FifoAw+1)'(FifoDepth) && !(pop && !not_empty))
    else $error("command queue over or under flow");

endmodule

>>> sv/tga_rle_back.sv
// ----------------------------------------------------------------------------
// tga_rle_back
// Result stage: pops commands, builds the result transaction and holds it in
// an output register until taken.
// ----------------------------------------------------------------------------
module tga_rle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  tga_rle_pkg::cmd_t  q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tga_rle_pkg::out_t  out_data
);
  import tga_rle_pkg::*;

  logic  out_valid_r, out_valid_nxt;
  out_t  out_data_r, out_data_nxt;

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  // Expand a command into a result
  always_comb begin
    out_data_nxt = out_data_r;
    if (q_pop) begin
      unique case (q_cmd.kind)
        CMD_PIXEL: begin
          out_data_nxt = '{pixel_value: q_cmd.pixel, repeat_count: q_cmd.rep,
                           image_done: q_cmd.done, status: STATUS_OK};
        end
        CMD_PIXEL_EARLY: begin
          out_data_nxt = '{pixel_value: q_cmd.pixel, repeat_count: q_cmd.rep,
                           image_done: 1'b0, status: STATUS_EARLY};
        end
        CMD_OVERRUN: begin
          out_data_nxt = '{pixel_value: 32'd0, repeat_count: 8'd0,
                           image_done: 1'b0, status: STATUS_OVERRUN};
        end
        default: begin
          out_data_nxt = '{pixel_value: 32'd0, repeat_count: 8'd0,
                           image_done: 1'b0, status: STATUS_EARLY};
        end
      endcase
    end
    out_valid_nxt = q_pop || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pop_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped command did not reach the output register");

endmodule

>>> verif/tga_rle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tga_rle_checker
// Watches the decoder's channels, predicts each result and compares it.
// ----------------------------------------------------------------------------
// Every accepted configuration write updates a private copy of the registers.
// Every accepted stream byte runs through a cycle-free model of the packet
// parser, which queues the result the byte causes, if any. Every accepted
// result is compared field by field against the oldest queued result.
module tga_rle_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  tga_rle_pkg::in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tga_rle_pkg::out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                fail_count,
  output int                pending_count
);
  import tga_rle_pkg::*;

  // Register copies
  logic [2:0]  bpp_reg;
  logic [31:0] image_pixels;

  // Parser state
  logic        in_pkt;
  logic        run_pkt;
  logic [7:0]  pkt_left;
  logic [1:0]  byte_pos;
  logic [31:0] gather;
  logic [31:0] pixels_done;

  out_t expected_pixels[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic clear_image();
    in_pkt      = 1'b0;
    run_pkt     = 1'b0;
    pkt_left    = '0;
    byte_pos    = '0;
    gather      = '0;
    pixels_done = '0;
  endtask

  task automatic queue_pixel(input logic [31:0] pix, input logic [7:0] rep,
                             input logic done, input logic [1:0] st);
    out_t r;
    r.pixel_value  = pix;
    r.repeat_count = rep;
    r.image_done   = done;
    r.status       = st;
    expected_pixels.push_back(r);
  endtask

  // Advance the parser by one stream byte
  task automatic decode_byte(input in_t item);
    int          size;
    logic [8:0]  len;
    logic [31:0] pix;
    logic [7:0]  rep;
    size = int'(bpp_reg);
    if (size < 1) size = 1;
    if (size > 4) size = 4;
    if (!in_pkt) begin
      // header byte: overrun check first, then early end
      len = {1'b0, item.data_byte & LEN_MASK} + 9'd1;
      if ({1'b0, pixels_done} + 33'(len) > {1'b0, image_pixels}) begin
        clear_image();
        queue_pixel('0, '0, 1'b0, STATUS_OVERRUN);
      end else if (item.last_byte) begin
        clear_image();
        queue_pixel('0, '0, 1'b0, STATUS_EARLY);
      end else begin
        in_pkt   = 1'b1;
        run_pkt  = (item.data_byte & RUN_FLAG) != 8'h00;
        pkt_left = len[7:0];
        byte_pos = '0;
        gather   = '0;
      end
    end else begin
      if (byte_pos == 2'd0) gather = {24'h0, item.data_byte};
      else gather = gather | (32'(item.data_byte) << (8 * byte_pos));
      if (int'(byte_pos) + 1 < size) begin
        if (item.last_byte) begin
          clear_image();
          queue_pixel('0, '0, 1'b0, STATUS_EARLY);
        end else begin
          byte_pos = byte_pos + 2'd1;
        end
      end else begin
        // pixel complete
        pix = gather;
        if (run_pkt) begin
          rep      = pkt_left;
          pkt_left = '0;
        end else begin
          rep      = 8'd1;
          pkt_left = pkt_left - 8'd1;
        end
        pixels_done = pixels_done + 32'(rep);
        byte_pos    = '0;
        gather      = '0;
        if (pkt_left == 8'd0) in_pkt = 1'b0;
        if (pixels_done >= image_pixels) begin
          clear_image();
          queue_pixel(pix, rep, 1'b1, STATUS_OK);
        end else if (item.last_byte) begin
          clear_image();
          queue_pixel(pix, rep, 1'b0, STATUS_EARLY);
        end else begin
          queue_pixel(pix, rep, 1'b0, STATUS_OK);
        end
      end
    end
  endtask

  // Compare one result against the oldest expectation
  task automatic check_pixel(input out_t got);
    out_t exp;
    if (expected_pixels.size() == 0) begin
      $error("unexpected result: pixel_value %0h repeat_count %0d image_done %0d status %0d",
             got.pixel_value, got.repeat_count, got.image_done, got.status);
      fail_count++;
    end else begin
      exp = expected_pixels.pop_front();
      if (got.pixel_value !== exp.pixel_value) begin
        $error("pixel_value: expected %0h, actual %0h", exp.pixel_value, got.pixel_value);
        fail_count++;
      end
      if (got.repeat_count !== exp.repeat_count) begin
        $error("repeat_count: expected %0d, actual %0d", exp.repeat_count, got.repeat_count);
        fail_count++;
      end
      if (got.image_done !== exp.image_done) begin
        $error("image_done: expected %0d, actual %0d", exp.image_done, got.image_done);
        fail_count++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        fail_count++;
      end
    end
  endtask

  // Sample every transaction at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      bpp_reg      = 3'd1;
      image_pixels = 32'd1;
      clear_image();
      expected_pixels.delete();
    end else begin
      if (out_valid && out_ready) check_pixel(out_data);
      if (in_valid && in_ready) decode_byte(in_data);
      // a write lands after the byte taken at the same edge
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BYTES_PER_PIXEL: bpp_reg = cfg_data[2:0];
          CFG_PIXEL_COUNT:     image_pixels = cfg_data;
          default: ;
        endcase
      end
    end
    pending_count = expected_pixels.size();
  end

endmodule

>>> verif/tb_tga_rle_pixel_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_core
// Stimulus and verdict for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
// A directed sequence covers single-pixel images, the longest run, pixel
// sizes at both ends, overrun headers and data that ends on a header, inside
// a pixel and after a pixel. Random phases then reprogram the pixel size and
// image size and send mostly well-formed packets with random content, mixed
// with noise bytes and packets cut short. Both sides idle in random bursts;
// the checker beside the decoder predicts and compares every result.
module tb_tga_rle_pixel_decoder_core;
  import tga_rle_pkg::*;

  localparam int RANDOM_BYTES = 1550;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int   fail_count;
  int   pending_count;
  int   bytes_sent = 0;
  int   stall_left = 0;
  int   stim_bpp = 1;
  logic quiet = 1'b0;

  always #10 clk = ~clk;

  tga_rle_pixel_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tga_rle_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hold one byte until accepted, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_t item;
    item.data_byte = b;
    item.last_byte = last;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result is back and the parser settles
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] bpp, input logic [31:0] pixels);
    drain();
    write_reg(CFG_BYTES_PER_PIXEL, {29'h0, bpp});
    write_reg(CFG_PIXEL_COUNT, pixels);
    stim_bpp = (bpp == 3'd0) ? 1 : (bpp > 3'd4) ? 4 : int'(bpp);
  endtask

  // One well-formed packet with random content; rarely cut short
  task automatic send_packet();
    int         len;
    int         npix;
    logic       run;
    logic [7:0] hdr;
    run = 1'($urandom_range(0, 1));
    if (run) len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
    else len = ($urandom_range(0, 39) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
    hdr = (run ? RUN_FLAG : 8'h00) | (8'(len - 1) & LEN_MASK);
    send_byte(hdr, 1'b0);
    npix = run ? 1 : len;
    for (int p = 0; p < npix; p++) begin
      for (int k = 0; k < stim_bpp; k++) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 149) == 0);
      end
    end
  endtask

  // Header alone, or header then up to one pixel of bytes, with the data ending
  task automatic send_broken();
    int cut;
    if ($urandom_range(0, 2) == 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      cut = $urandom_range(1, stim_bpp);
      for (int k = 1; k < cut; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic pick_config();
    logic [2:0]  bpp;
    logic [31:0] pixels;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) bpp = 3'd0;
    else if (sel == 1) bpp = 3'($urandom_range(5, 7));
    else bpp = 3'($urandom_range(1, 4));
    sel = $urandom_range(0, 19);
    case (sel)
      0:       pixels = 32'd0;
      1:       pixels = 32'hFFFF_FFFF;
      2:       pixels = 32'd4294836225;
      3:       pixels = 32'h8000_0000;
      default: pixels = 32'($urandom_range(1, 60));
    endcase
    set_config(bpp, pixels);
  endtask

  initial begin
    int start;
    int budget;
    int kind;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_BYTES_PER_PIXEL;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes: one-byte pixels, one-pixel image
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(RUN_FLAG, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);

    // Four-byte pixels: longest run, data ending inside, on and after a pixel
    set_config(3'd4, 32'd300);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Zero image size overruns; out-of-range pixel sizes
    set_config(3'd0, 32'd0);
    send_byte(8'h00, 1'b0);
    set_config(3'd7, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h81, 1'b1);

    // Random phases
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      pick_config();
      budget = $urandom_range(60, 200);
      while (budget > 0 && bytes_sent - start < RANDOM_BYTES) begin
        budget -= 1;
        kind = $urandom_range(0, 99);
        if (kind < 80) send_packet();
        else if (kind < 90) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
        else send_broken();
        if (bytes_sent - start > RANDOM_BYTES - 150) quiet = 1'b1;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
sv/tga_rle_pkg.sv
sv/tga_rle_front.sv
sv/tga_rle_fifo.sv
sv/tga_rle_back.sv
sv/tga_rle_pixel_decoder_core.sv
verif/tga_rle_checker.sv
verif/tb_tga_rle_pixel_decoder_core.sv
